// ===== hdl/sfd_pkg.sv =====
package sfd_pkg;

    localparam int STORE_DEPTH    = 65536;
    localparam int SAMPLE_BITS    = 16;
    localparam int ADDR_BITS      = $clog2(STORE_DEPTH);
    localparam int DELAY_BITS     = 16;
    localparam int GAIN_BITS      = 16;
    localparam int CFG_INDEX_BITS = 3;
    localparam int CFG_DATA_BITS  = 16;

    localparam int TAP_SUM_BITS   = SAMPLE_BITS + 1;
    localparam int FB_PROD_BITS   = TAP_SUM_BITS + GAIN_BITS;
    localparam int DRY_PROD_BITS  = SAMPLE_BITS + GAIN_BITS + 1;
    localparam int WET_PROD_BITS  = TAP_SUM_BITS + GAIN_BITS + 1;
    localparam int WIDE_BITS      = WET_PROD_BITS + 1;

    // feedback is scaled by 2^16 (tap sum carries one extra bit), mix by 2^15
    localparam int FB_SHIFT       = GAIN_BITS;
    localparam int MIX_SHIFT      = GAIN_BITS - 1;

    typedef logic signed [SAMPLE_BITS-1:0]  sample_t;
    typedef logic        [ADDR_BITS-1:0]    addr_t;
    typedef logic        [DELAY_BITS-1:0]   delay_t;
    typedef logic signed [GAIN_BITS-1:0]    gain_t;
    typedef logic        [GAIN_BITS-1:0]    wet_t;
    typedef logic signed [GAIN_BITS:0]      gain_ext_t;
    typedef logic signed [TAP_SUM_BITS-1:0] tap_sum_t;
    typedef logic signed [WIDE_BITS-1:0]    wide_t;

    typedef enum logic [1:0] {
        MODE_NORMAL,
        MODE_EXTRA_TAP,
        MODE_AVG_TAP,
        MODE_PING_PONG
    } mode_t;

    typedef enum logic [CFG_INDEX_BITS-1:0] {
        REG_MODE,
        REG_FEEDBACK_GAIN,
        REG_WET_GAIN,
        REG_LEFT_MAIN_DELAY,
        REG_RIGHT_MAIN_DELAY,
        REG_LEFT_TAP_DELAY,
        REG_RIGHT_TAP_DELAY
    } cfg_reg_t;

    localparam wet_t      WET_UNITY  = wet_t'(1 << (GAIN_BITS - 1));
    localparam gain_ext_t GAIN_UNITY = gain_ext_t'(1 << (GAIN_BITS - 1));
    localparam wide_t     SAMPLE_MAX = wide_t'((longint'(1) << (SAMPLE_BITS - 1)) - 1);
    localparam wide_t     SAMPLE_MIN = -SAMPLE_MAX - wide_t'(1);
    localparam wide_t     FB_HALF    = wide_t'(1 << (FB_SHIFT - 1));
    localparam wide_t     MIX_HALF   = wide_t'(1 << (MIX_SHIFT - 1));

    typedef struct packed {
        sample_t left_in;
        sample_t right_in;
    } in_item_t;

    typedef struct packed {
        sample_t left_mix;
        sample_t right_mix;
    } out_item_t;

    typedef struct packed {
        mode_t mode;
        gain_t fb_gain;
        wet_t  wet_gain;
    } lane_cfg_t;

    typedef struct packed {
        logic    en;
        addr_t   addr;
        sample_t data;
    } mem_wr_t;

    typedef struct packed {
        sample_t                          sample;
        logic signed [FB_PROD_BITS-1:0]   fb_prod;
        logic signed [DRY_PROD_BITS-1:0]  dry_prod;
        logic signed [WET_PROD_BITS-1:0]  wet_prod;
    } lane_prod_t;

    function automatic addr_t delay_addr(input addr_t wp, input delay_t delay);
        logic [31:0] d;
        d = 32'(delay);
        if (d == 32'd0) begin
            d = 32'd1;
        end
        if (d >= 32'(STORE_DEPTH)) begin
            d = 32'(STORE_DEPTH - 1);
        end
        return wp - d[ADDR_BITS-1:0];
    endfunction

    function automatic sample_t sat_sample(input wide_t v);
        if (v > SAMPLE_MAX) begin
            return sample_t'(SAMPLE_MAX);
        end
        if (v < SAMPLE_MIN) begin
            return sample_t'(SAMPLE_MIN);
        end
        return sample_t'(v);
    endfunction

endpackage

// ===== hdl/sfd_lane.sv =====
module sfd_lane (
    input  logic               aclk,
    input  logic               rd_en,
    input  sfd_pkg::addr_t     wp,
    input  sfd_pkg::delay_t    main_delay,
    input  sfd_pkg::delay_t    tap_delay,
    input  sfd_pkg::sample_t   sample_in,
    input  logic               adv,
    input  sfd_pkg::lane_cfg_t cfg,
    input  sfd_pkg::mem_wr_t   wr,
    output sfd_pkg::lane_prod_t prod
);
    import sfd_pkg::*;

    sample_t    mem_reg [STORE_DEPTH];
    sample_t    main_reg;
    sample_t    tap_reg;
    sample_t    sample_reg;
    lane_prod_t prod_reg;
    lane_prod_t prod_next;

    addr_t      main_addr;
    addr_t      tap_addr;
    tap_sum_t   main_x;
    tap_sum_t   tap_x;
    tap_sum_t   wet_sum;
    tap_sum_t   fb_src;
    gain_ext_t  wet_s;
    gain_ext_t  dry_s;

    assign main_addr = delay_addr(wp, main_delay);
    assign tap_addr  = delay_addr(wp, tap_delay);

    // two reads and one write per cycle; a read of the address being written takes the new data
    always_ff @(posedge aclk) begin
        if (wr.en) begin
            mem_reg[wr.addr] <= wr.data;
        end
        if (rd_en) begin
            main_reg   <= (wr.en && (wr.addr == main_addr)) ? wr.data : mem_reg[main_addr];
            tap_reg    <= (wr.en && (wr.addr == tap_addr)) ? wr.data : mem_reg[tap_addr];
            sample_reg <= sample_in;
        end
    end

    always_comb begin
        main_x = tap_sum_t'(main_reg);
        if (cfg.mode == MODE_EXTRA_TAP || cfg.mode == MODE_AVG_TAP) begin
            tap_x = tap_sum_t'(tap_reg);
        end else begin
            tap_x = '0;
        end
        wet_sum = main_x + tap_x;
        // shift-16 rounding for all modes: single tap is doubled
        if (cfg.mode == MODE_AVG_TAP) begin
            fb_src = wet_sum;
        end else begin
            fb_src = main_x <<< 1;
        end
        wet_s = gain_ext_t'({1'b0, cfg.wet_gain});
        dry_s = GAIN_UNITY - wet_s;

        prod_next.sample   = sample_reg;
        prod_next.fb_prod  = FB_PROD_BITS'(fb_src) * FB_PROD_BITS'(cfg.fb_gain);
        prod_next.dry_prod = DRY_PROD_BITS'(sample_reg) * DRY_PROD_BITS'(dry_s);
        prod_next.wet_prod = WET_PROD_BITS'(wet_sum) * WET_PROD_BITS'(wet_s);
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            prod_reg <= prod_next;
        end
    end

    assign prod = prod_reg;

endmodule

// ===== hdl/sfd_merge.sv =====
module sfd_merge (
    input  sfd_pkg::mode_t      mode,
    input  sfd_pkg::lane_prod_t left_prod,
    input  sfd_pkg::lane_prod_t right_prod,
    output sfd_pkg::sample_t    left_wr,
    output sfd_pkg::sample_t    right_wr,
    output sfd_pkg::out_item_t  result
);
    import sfd_pkg::*;

    wide_t fb_left;
    wide_t fb_right;
    wide_t in_left;
    wide_t in_right;
    wide_t mix_left;
    wide_t mix_right;

    always_comb begin
        fb_left   = (wide_t'(left_prod.fb_prod) + FB_HALF) >>> FB_SHIFT;
        fb_right  = (wide_t'(right_prod.fb_prod) + FB_HALF) >>> FB_SHIFT;
        in_left   = wide_t'(left_prod.sample);
        in_right  = wide_t'(right_prod.sample);

        if (mode == MODE_PING_PONG) begin
            left_wr  = sat_sample(in_right + fb_right);
            right_wr = sat_sample(in_left + fb_left);
        end else begin
            left_wr  = sat_sample(in_left + fb_left);
            right_wr = sat_sample(in_right + fb_right);
        end

        mix_left  = (wide_t'(left_prod.dry_prod) + wide_t'(left_prod.wet_prod) + MIX_HALF)
                    >>> MIX_SHIFT;
        mix_right = (wide_t'(right_prod.dry_prod) + wide_t'(right_prod.wet_prod) + MIX_HALF)
                    >>> MIX_SHIFT;
        result.left_mix  = sat_sample(mix_left);
        result.right_mix = sat_sample(mix_right);
    end

endmodule

// ===== hdl/stereo_feedback_delay.sv =====
// A result goes through the read, product and output registers once its input is accepted;
// no input is accepted while the read stage holds one. A tap may read the sample written by
// the previous transaction, and that write lands two stages after its memory read.
// Reset (aresetn low, synchronous): control registers to defaults, then a clearing pass
// zeroes all 65536 addresses of both delay memories; s_ready stays low until it completes.
module stereo_feedback_delay (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    input  logic                                  s_valid,
    output logic                                  s_ready,
    input  sfd_pkg::in_item_t                     s_data,
    output logic                                  m_valid,
    input  logic                                  m_ready,
    output sfd_pkg::out_item_t                    m_data,
    input  logic                                  cfg_wr_en,
    input  logic [sfd_pkg::CFG_INDEX_BITS-1:0]    cfg_addr,
    input  logic [sfd_pkg::CFG_DATA_BITS-1:0]     cfg_wdata
);
    import sfd_pkg::*;

    typedef enum logic {
        ST_CLEAR,
        ST_RUN
    } state_t;

    state_t    state_reg, state_next;
    addr_t     clear_cnt_reg, clear_cnt_next;
    addr_t     wp_reg, wp_next;
    addr_t     wp1_reg, wp1_next;
    addr_t     wp2_reg, wp2_next;
    logic      st1_valid_reg, st1_valid_next;
    logic      st2_valid_reg, st2_valid_next;
    logic      out_valid_reg, out_valid_next;
    out_item_t out_reg, out_next;

    mode_t     mode_reg;
    gain_t     fb_gain_reg;
    wet_t      wet_gain_reg;
    delay_t    left_main_delay_reg;
    delay_t    right_main_delay_reg;
    delay_t    left_tap_delay_reg;
    delay_t    right_tap_delay_reg;

    logic       accept;
    logic       adv1;
    logic       adv2;
    logic       st2_free;
    lane_cfg_t  lane_cfg;
    mem_wr_t    left_wr;
    mem_wr_t    right_wr;
    lane_prod_t left_prod;
    lane_prod_t right_prod;
    sample_t    left_wr_data;
    sample_t    right_wr_data;
    out_item_t  result;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg             <= MODE_NORMAL;
            fb_gain_reg          <= '0;
            wet_gain_reg         <= '0;
            left_main_delay_reg  <= delay_t'(1);
            right_main_delay_reg <= delay_t'(1);
            left_tap_delay_reg   <= delay_t'(1);
            right_tap_delay_reg  <= delay_t'(1);
        end else if (cfg_wr_en) begin
            case (cfg_addr)
                REG_MODE:             mode_reg <= mode_t'(cfg_wdata[1:0]);
                REG_FEEDBACK_GAIN:    fb_gain_reg <= gain_t'(cfg_wdata);
                REG_WET_GAIN:         wet_gain_reg <= (wet_t'(cfg_wdata) > WET_UNITY) ?
                                                      WET_UNITY : wet_t'(cfg_wdata);
                REG_LEFT_MAIN_DELAY:  left_main_delay_reg <= delay_t'(cfg_wdata);
                REG_RIGHT_MAIN_DELAY: right_main_delay_reg <= delay_t'(cfg_wdata);
                REG_LEFT_TAP_DELAY:   left_tap_delay_reg <= delay_t'(cfg_wdata);
                REG_RIGHT_TAP_DELAY:  right_tap_delay_reg <= delay_t'(cfg_wdata);
                default: ;
            endcase
        end
    end

    assign lane_cfg.mode     = mode_reg;
    assign lane_cfg.fb_gain  = fb_gain_reg;
    assign lane_cfg.wet_gain = wet_gain_reg;

    assign adv2     = st2_valid_reg && (!out_valid_reg || m_ready);
    assign st2_free = !st2_valid_reg || adv2;
    assign adv1     = st1_valid_reg && st2_free;
    assign s_ready  = (state_reg == ST_RUN) && !st1_valid_reg && st2_free;
    assign accept   = s_valid && s_ready;

    always_comb begin
        state_next     = state_reg;
        clear_cnt_next = clear_cnt_reg;
        wp_next        = wp_reg;
        wp1_next       = wp1_reg;
        wp2_next       = wp2_reg;
        st1_valid_next = st1_valid_reg;
        st2_valid_next = st2_valid_reg;
        out_valid_next = out_valid_reg;
        out_next       = out_reg;

        case (state_reg)
            ST_CLEAR: begin
                clear_cnt_next = clear_cnt_reg + addr_t'(1);
                if (clear_cnt_reg == addr_t'(STORE_DEPTH - 1)) begin
                    state_next = ST_RUN;
                end
            end
            ST_RUN: begin
                if (m_valid && m_ready) begin
                    out_valid_next = 1'b0;
                end
                if (adv2) begin
                    out_valid_next = 1'b1;
                    out_next       = result;
                    st2_valid_next = 1'b0;
                end
                if (adv1) begin
                    st2_valid_next = 1'b1;
                    wp2_next       = wp1_reg;
                    st1_valid_next = 1'b0;
                end
                if (accept) begin
                    st1_valid_next = 1'b1;
                    wp1_next       = wp_reg;
                    wp_next        = wp_reg + addr_t'(1);
                end
            end
            default: begin
                state_next = ST_CLEAR;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_CLEAR;
            clear_cnt_reg <= '0;
            wp_reg        <= '0;
            st1_valid_reg <= 1'b0;
            st2_valid_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            clear_cnt_reg <= clear_cnt_next;
            wp_reg        <= wp_next;
            st1_valid_reg <= st1_valid_next;
            st2_valid_reg <= st2_valid_next;
            out_valid_reg <= out_valid_next;
        end
        wp1_reg <= wp1_next;
        wp2_reg <= wp2_next;
        out_reg <= out_next;
    end

    always_comb begin
        if (state_reg == ST_CLEAR) begin
            left_wr.en    = 1'b1;
            left_wr.addr  = clear_cnt_reg;
            left_wr.data  = '0;
            right_wr.en   = 1'b1;
            right_wr.addr = clear_cnt_reg;
            right_wr.data = '0;
        end else begin
            left_wr.en    = adv2;
            left_wr.addr  = wp2_reg;
            left_wr.data  = left_wr_data;
            right_wr.en   = adv2;
            right_wr.addr = wp2_reg;
            right_wr.data = right_wr_data;
        end
    end

    sfd_lane u_lane_left (
        .aclk       (aclk),
        .rd_en      (accept),
        .wp         (wp_reg),
        .main_delay (left_main_delay_reg),
        .tap_delay  (left_tap_delay_reg),
        .sample_in  (s_data.left_in),
        .adv        (adv1),
        .cfg        (lane_cfg),
        .wr         (left_wr),
        .prod       (left_prod)
    );

    sfd_lane u_lane_right (
        .aclk       (aclk),
        .rd_en      (accept),
        .wp         (wp_reg),
        .main_delay (right_main_delay_reg),
        .tap_delay  (right_tap_delay_reg),
        .sample_in  (s_data.right_in),
        .adv        (adv1),
        .cfg        (lane_cfg),
        .wr         (right_wr),
        .prod       (right_prod)
    );

    sfd_merge u_merge (
        .mode       (mode_reg),
        .left_prod  (left_prod),
        .right_prod (right_prod),
        .left_wr    (left_wr_data),
        .right_wr   (right_wr_data),
        .result     (result)
    );

    assign m_valid = out_valid_reg;
    assign m_data  = out_reg;

`ifndef SYNTHESIS
    a_accept_spacing: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> !(s_valid && s_ready))
        else $error("input transactions accepted on consecutive cycles");

    a_write_behind_wp: assert property (@(posedge aclk) disable iff (!aresetn)
        adv2 |-> (((wp_reg - wp2_reg) == addr_t'(1)) || ((wp_reg - wp2_reg) == addr_t'(2))))
        else $error("memory write address out of step with write pointer");

    a_clear_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_CLEAR) |-> !(st1_valid_reg || st2_valid_reg || out_valid_reg))
        else $error("pipeline busy during memory clear");

    a_result_source: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(out_valid_reg) |-> $past(st2_valid_reg))
        else $error("result without a transaction in the last stage");
`endif

endmodule
